// File: sv/ship_bip_dueling_rrip_replacement_defines.svh
// assertion macros for the ship/bip dueling rrip replacement unit
// no dependencies; included by the top level only
`ifndef SHIP_BIP_DUELING_RRIP_REPLACEMENT_DEFINES_SVH
`define SHIP_BIP_DUELING_RRIP_REPLACEMENT_DEFINES_SVH

// consequence checked in the same cycle
`define SBDR_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("sbdr assertion failed");

// consequence checked in the next cycle
`define SBDR_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("sbdr assertion failed");

`endif

// File: sv/sbdr_pkg.sv
// shared constants for the ship/bip dueling rrip replacement unit
// no dependencies; imported by sbdr_victim and the top level
package sbdr_pkg;

    // default sizes
    localparam int NUM_SETS_DEF      = 2048;
    localparam int NUM_WAYS_DEF      = 16;
    localparam int SIG_ENTRIES_DEF   = 4096;
    localparam int SELECTOR_BITS_DEF = 10;

    // field widths
    localparam int SET_IDX_W = 11;
    localparam int WAY_W     = 4;
    localparam int PC_W      = 24;
    localparam int SEL_OUT_W = 10;
    localparam int THR_W     = 2;
    localparam int RATE_W    = 3;
    localparam int LEAD_W    = 11;

    // stream packing
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int SET_LSB   = 0;
    localparam int WAY_LSB   = 11;
    localparam int PC_LSB    = 15;
    localparam int OP_BIT    = 0;
    localparam int HIT_BIT   = 1;

    // config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_REUSE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIP_RATE_LOG2   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_SETS     = 2'd2;
    localparam logic [THR_W-1:0]  THR_RST  = 2'd2;
    localparam logic [RATE_W-1:0] RATE_RST = 3'd5;
    localparam logic [LEAD_W-1:0] LEAD_RST = 11'd32;

    // operation codes
    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // rrpv and counter values
    localparam int RRPV_W = 2;
    localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;
    localparam logic [RRPV_W-1:0] RRPV_NEAR = 2'd0;
    localparam int CTR_W = 2;
    localparam logic [CTR_W-1:0] CTR_MAX  = 2'd3;
    localparam logic [CTR_W-1:0] CTR_INIT = 2'd2;

    // signature hash shift
    localparam int SIG_SHIFT = 12;

endpackage

// File: sv/sbdr_victim.sv
// victim selection and set aging over one row of rrpv values
// depends on sbdr_pkg
module sbdr_victim
    import sbdr_pkg::*;
#(
    parameter int NUM_WAYS = NUM_WAYS_DEF
) (
    input  logic [NUM_WAYS-1:0][RRPV_W-1:0]  rrpv_i,
    output logic [NUM_WAYS-1:0][RRPV_W-1:0]  aged_o,
    output logic [$clog2(NUM_WAYS)-1:0]      victim_o
);

    localparam int WAY_BITS = $clog2(NUM_WAYS);

    logic              has1;
    logic              has2;
    logic              has3;
    logic [RRPV_W-1:0] top;
    logic [RRPV_W-1:0] delta;

    always_comb begin
        has1 = 1'b0;
        has2 = 1'b0;
        has3 = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            has1 = has1 | (rrpv_i[w] == 2'd1);
            has2 = has2 | (rrpv_i[w] == 2'd2);
            has3 = has3 | (rrpv_i[w] == RRPV_MAX);
        end
        if (has3) begin
            top = RRPV_MAX;
        end else if (has2) begin
            top = 2'd2;
        end else if (has1) begin
            top = 2'd1;
        end else begin
            top = 2'd0;
        end
        delta = RRPV_MAX - top;
        for (int w = 0; w < NUM_WAYS; w++) begin
            aged_o[w] = rrpv_i[w] + delta;
        end
        // lowest way holding the set maximum
        victim_o = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (rrpv_i[w] == top) begin
                victim_o = WAY_BITS'(w);
            end
        end
    end

endmodule

// File: sv/ship_bip_dueling_rrip_replacement.sv
// top level of the ship/bip dueling rrip replacement unit: set row and counter memories
// depends on sbdr_pkg, sbdr_victim and ship_bip_dueling_rrip_replacement_defines.svh
//
// channel  | dir | payload
// s_       | in  | tdata: set_index, way, pc; tuser: op, hit
// m_       | out | tdata: victim_way, selector_value
// cfg_     | in  | cfg_index, cfg_wdata (no handshake)
//
// victim requests and hit updates pass through the registered set row read (S_ROW); miss fills add
// the counter read of the evicted signature (S_CTR)
// after reset a sweep over max(NUM_SETS, SIG_ENTRIES) addresses (4096 by default) initializes both
// memories; no transaction is taken meanwhile, config writes are taken
// the result sits in an output register; a new transaction is taken while it waits,
// and the final step holds until that register is free
`include "ship_bip_dueling_rrip_replacement_defines.svh"

module ship_bip_dueling_rrip_replacement
    import sbdr_pkg::*;
#(
    parameter int NUM_SETS      = NUM_SETS_DEF,
    parameter int NUM_WAYS      = NUM_WAYS_DEF,
    parameter int SIG_ENTRIES   = SIG_ENTRIES_DEF,
    parameter int SELECTOR_BITS = SELECTOR_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // set_index[10:0], way[14:11], pc[38:15], zero
    input  logic [S_TUSER_W-1:0]  s_tuser,   // op[0], hit[1]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // victim_way[3:0], selector_value[13:4], zero
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // sizes assumed powers of two
    localparam int SET_BITS  = $clog2(NUM_SETS);
    localparam int WAY_BITS  = $clog2(NUM_WAYS);
    localparam int SIG_BITS  = $clog2(SIG_ENTRIES);
    localparam int ENTRY_W   = SIG_BITS + RRPV_W + 1;
    localparam int REUSE_BIT = RRPV_W;
    localparam int SIG_LSB   = RRPV_W + 1;
    localparam int CLR_DEPTH = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
    localparam int CLR_BITS  = $clog2(CLR_DEPTH);
    localparam int CMP_W     = SET_BITS + LEAD_W + 1;

    typedef logic [NUM_WAYS-1:0][ENTRY_W-1:0] row_t;
    typedef enum logic [1:0] {S_IDLE, S_ROW, S_CTR} state_t;

    row_t                set_mem [NUM_SETS];
    logic [CTR_W-1:0]    ctr_mem [SIG_ENTRIES];

    state_t              state_reg;
    state_t              state_next;
    logic                clr_active_reg;
    logic [CLR_BITS-1:0] clr_addr_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [SELECTOR_BITS-1:0] sel_reg;
    logic [SELECTOR_BITS-1:0] sel_next;
    logic [THR_W-1:0]    thr_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [LEAD_W-1:0]   lead_reg;

    // item registers
    logic                op_reg;
    logic                hit_reg;
    logic                way_ok_reg;
    logic [WAY_BITS-1:0] way_idx_reg;
    logic [SET_BITS-1:0] set_addr_reg;
    logic [SIG_BITS-1:0] nsig_reg;
    logic                bip_near_reg;
    logic                ship_lead_reg;
    logic                bip_lead_reg;
    logic [SIG_BITS-1:0] old_sig_reg;
    logic [CTR_W-1:0]    ctr_new_reg;

    // memory ports
    row_t                set_rd_reg;
    logic                set_re;
    logic                set_we;
    logic [SET_BITS-1:0] set_waddr;
    row_t                set_wdata;
    logic [CTR_W-1:0]    ctr_rd_reg;
    logic                ctr_re;
    logic [SIG_BITS-1:0] ctr_raddr;
    logic                ctr_we;
    logic [SIG_BITS-1:0] ctr_waddr;
    logic [CTR_W-1:0]    ctr_wdata;

    // input decode
    logic                      accept;
    logic                      in_op;
    logic                      in_hit;
    logic [SET_IDX_W-1:0]      in_set;
    logic [WAY_W-1:0]          in_way;
    logic [PC_W-1:0]           in_pc;
    logic [SET_BITS+SET_IDX_W-1:0] set_ext;
    logic [SET_BITS-1:0]       set_addr;
    logic [WAY_BITS+WAY_W-1:0] way_ext;
    logic [WAY_BITS-1:0]       way_idx;
    logic                      way_ok;
    logic [PC_W-1:0]           pc_hash;
    logic [SIG_BITS-1:0]       pc_sig;
    logic [PC_W-1:0]           bip_mask;
    logic                      bip_near;
    logic [CMP_W-1:0]          set_cmp;
    logic                      ship_lead;
    logic                      bip_lead;

    // row processing
    logic [NUM_WAYS-1:0][RRPV_W-1:0] rrpv_vec;
    logic [NUM_WAYS-1:0][RRPV_W-1:0] aged_vec;
    logic [WAY_BITS-1:0]       victim;
    row_t                      row_victim;
    row_t                      row_hit;
    row_t                      row_fill;
    row_t                      clr_row;
    logic [SIG_BITS-1:0]       row_old_sig;
    logic                      row_old_reused;
    logic [CTR_W-1:0]          trained;
    logic [CTR_W-1:0]          new_ctr;
    logic                      ship_pick;
    logic                      fill_near;
    logic                      out_free;
    logic                      out_load;
    logic [WAY_BITS-1:0]       out_victim;
    logic [WAY_BITS+WAY_W-1:0] vic_ext;
    logic [SELECTOR_BITS+SEL_OUT_W-1:0] sel_ext;
    logic                      clr_set_en;
    logic                      clr_ctr_en;

    assign in_op  = s_tuser[OP_BIT];
    assign in_hit = s_tuser[HIT_BIT];
    assign in_set = s_tdata[SET_LSB +: SET_IDX_W];
    assign in_way = s_tdata[WAY_LSB +: WAY_W];
    assign in_pc  = s_tdata[PC_LSB +: PC_W];

    assign s_tready = (state_reg == S_IDLE) && !clr_active_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        set_ext  = {{SET_BITS{1'b0}}, in_set};
        set_addr = set_ext[SET_BITS-1:0];
        way_ext  = {{WAY_BITS{1'b0}}, in_way};
        way_idx  = way_ext[WAY_BITS-1:0];
        way_ok   = way_ext < (WAY_BITS + WAY_W)'(NUM_WAYS);
        pc_hash  = in_pc ^ (in_pc >> SIG_SHIFT);
        pc_sig   = pc_hash[SIG_BITS-1:0];
        bip_mask = ~({PC_W{1'b1}} << rate_reg);
        bip_near = (in_pc & bip_mask) == '0;
        set_cmp  = CMP_W'(set_addr);
        ship_lead = set_cmp < CMP_W'(lead_reg);
        bip_lead  = !ship_lead && (set_cmp < CMP_W'({lead_reg, 1'b0}));
    end

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            rrpv_vec[w] = set_rd_reg[w][RRPV_W-1:0];
        end
    end

    sbdr_victim #(
        .NUM_WAYS (NUM_WAYS)
    ) u_victim (
        .rrpv_i   (rrpv_vec),
        .aged_o   (aged_vec),
        .victim_o (victim)
    );

    always_comb begin
        row_victim = set_rd_reg;
        for (int w = 0; w < NUM_WAYS; w++) begin
            row_victim[w][RRPV_W-1:0] = aged_vec[w];
            clr_row[w] = ENTRY_W'(RRPV_MAX);
        end
        row_old_sig    = set_rd_reg[way_idx_reg][SIG_LSB +: SIG_BITS];
        row_old_reused = set_rd_reg[way_idx_reg][REUSE_BIT];

        row_hit = set_rd_reg;
        row_hit[way_idx_reg][RRPV_W-1:0] = RRPV_NEAR;
        row_hit[way_idx_reg][REUSE_BIT]  = 1'b1;

        // signature counter training on the evicted line
        if (row_old_reused) begin
            trained = (ctr_rd_reg != CTR_MAX) ? ctr_rd_reg + 1'b1 : ctr_rd_reg;
        end else begin
            trained = (ctr_rd_reg != '0) ? ctr_rd_reg - 1'b1 : ctr_rd_reg;
        end
        new_ctr   = (old_sig_reg == nsig_reg) ? trained : ctr_new_reg;
        // followers read the selector msb: above half of the range
        ship_pick = ship_lead_reg || (!bip_lead_reg && sel_reg[SELECTOR_BITS-1]);
        fill_near = ship_pick ? (new_ctr >= thr_reg) : bip_near_reg;

        row_fill = set_rd_reg;
        row_fill[way_idx_reg] = {nsig_reg, 1'b0, fill_near ? RRPV_NEAR : RRPV_MAX};

        clr_set_en = {1'b0, clr_addr_reg} < (CLR_BITS + 1)'(NUM_SETS);
        clr_ctr_en = {1'b0, clr_addr_reg} < (CLR_BITS + 1)'(SIG_ENTRIES);
    end

    always_comb begin
        state_next = state_reg;
        set_re     = accept;
        set_we     = 1'b0;
        set_waddr  = set_addr_reg;
        set_wdata  = set_rd_reg;
        ctr_re     = 1'b0;
        ctr_raddr  = pc_sig;
        ctr_we     = 1'b0;
        ctr_waddr  = old_sig_reg;
        ctr_wdata  = trained;
        out_load   = 1'b0;
        out_victim = '0;
        sel_next   = sel_reg;
        if (clr_active_reg) begin
            set_we    = clr_set_en;
            set_waddr = clr_addr_reg[SET_BITS-1:0];
            set_wdata = clr_row;
            ctr_we    = clr_ctr_en;
            ctr_waddr = clr_addr_reg[SIG_BITS-1:0];
            ctr_wdata = CTR_INIT;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        ctr_re     = 1'b1;
                        state_next = S_ROW;
                    end
                end
                S_ROW: begin
                    if (op_reg == OP_VICTIM) begin
                        if (out_free) begin
                            set_we     = 1'b1;
                            set_wdata  = row_victim;
                            out_load   = 1'b1;
                            out_victim = victim;
                            state_next = S_IDLE;
                        end
                    end else if (!way_ok_reg) begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end else if (hit_reg) begin
                        if (out_free) begin
                            set_we     = 1'b1;
                            set_wdata  = row_hit;
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end else begin
                        // fetch the evicted line's counter
                        ctr_re     = 1'b1;
                        ctr_raddr  = row_old_sig;
                        state_next = S_CTR;
                    end
                end
                S_CTR: begin
                    if (out_free) begin
                        ctr_we    = 1'b1;
                        set_we    = 1'b1;
                        set_wdata = row_fill;
                        if (ship_lead_reg) begin
                            if (sel_reg != '0) begin
                                sel_next = sel_reg - 1'b1;
                            end
                        end else if (bip_lead_reg) begin
                            if (sel_reg != '1) begin
                                sel_next = sel_reg + 1'b1;
                            end
                        end
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                default: begin
                    state_next = S_IDLE;
                end
            endcase
        end
        vic_ext = {{WAY_W{1'b0}}, out_victim};
        sel_ext = {{SEL_OUT_W{1'b0}}, sel_next};
    end

    // set row memory
    always_ff @(posedge aclk) begin
        if (set_we) begin
            set_mem[set_waddr] <= set_wdata;
        end
        if (set_re) begin
            set_rd_reg <= set_mem[set_addr];
        end
    end

    // signature counter memory
    always_ff @(posedge aclk) begin
        if (ctr_we) begin
            ctr_mem[ctr_waddr] <= ctr_wdata;
        end
        if (ctr_re) begin
            ctr_rd_reg <= ctr_mem[ctr_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            sel_reg        <= {1'b0, {(SELECTOR_BITS-1){1'b1}}};
            thr_reg        <= THR_RST;
            rate_reg       <= RATE_RST;
            lead_reg       <= LEAD_RST;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == CLR_BITS'(CLR_DEPTH - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= M_TDATA_W'({sel_ext[SEL_OUT_W-1:0], vic_ext[WAY_W-1:0]});
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wen) begin
                case (cfg_index)
                    CFG_REUSE_THRESHOLD: thr_reg  <= cfg_wdata[THR_W-1:0];
                    CFG_BIP_RATE_LOG2:   rate_reg <= cfg_wdata[RATE_W-1:0];
                    CFG_LEADER_SETS:     lead_reg <= cfg_wdata[LEAD_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                op_reg        <= in_op;
                hit_reg       <= in_hit;
                way_ok_reg    <= way_ok;
                way_idx_reg   <= way_idx;
                set_addr_reg  <= set_addr;
                nsig_reg      <= pc_sig;
                bip_near_reg  <= bip_near;
                ship_lead_reg <= ship_lead;
                bip_lead_reg  <= bip_lead;
            end
            if (state_reg == S_ROW && state_next == S_CTR) begin
                old_sig_reg <= row_old_sig;
                ctr_new_reg <= ctr_rd_reg;
            end
        end
    end

    `SBDR_ASSERT_SAME(a_no_accept_in_clear, aclk, aresetn, clr_active_reg, !s_tready)
    `SBDR_ASSERT_NEXT(a_accept_reads_row, aclk, aresetn, s_tvalid && s_tready, state_reg == S_ROW)
    `SBDR_ASSERT_NEXT(a_sel_only_on_fill, aclk, aresetn, state_reg != S_CTR, $stable(sel_reg))

endmodule

// File: bench/tb_top.sv
// testbench for ship_bip_dueling_rrip_replacement: directed table, then random access streams
// checked per transaction against an rrpv/signature/duel-selector predictor kept in the bench
// depends on sbdr_pkg and the rtl of the replacement unit
`timescale 1ns / 1ps

module tb_top;
    import sbdr_pkg::*;

    localparam int SIG_W       = $clog2(SIG_ENTRIES_DEF);
    localparam int SEL_TOP     = (1 << SELECTOR_BITS_DEF) - 1;
    localparam int SEL_MID     = SEL_TOP / 2;
    localparam int VICT_LSB    = 0;
    localparam int SELV_LSB    = WAY_W;
    localparam int HOLD_CYCLES = 100;
    localparam logic HIT  = 1'b1;
    localparam logic MISS = 1'b0;

    typedef struct packed {
        logic                 op;
        logic [SET_IDX_W-1:0] set_idx;
        logic [WAY_W-1:0]     way;
        logic [PC_W-1:0]      pc;
        logic                 hit;
    } access_t;

    typedef struct packed {
        logic [SEL_OUT_W-1:0] sel;
        logic [WAY_W-1:0]     victim;
    } rrip_out_t;

    typedef struct packed {
        logic                 op;
        logic [SET_IDX_W-1:0] set_idx;
        logic [WAY_W-1:0]     way;
        logic [PC_W-1:0]      pc;
        logic                 hit;
        logic                 fixed;
        logic [WAY_W-1:0]     victim;
        logic [SEL_OUT_W-1:0] sel;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // predicted replacement state
    logic [RRPV_W-1:0]    rrpv_mem   [NUM_SETS_DEF][NUM_WAYS_DEF];
    bit                   reused_mem [NUM_SETS_DEF][NUM_WAYS_DEF];
    logic [SIG_W-1:0]     sig_mem    [NUM_SETS_DEF][NUM_WAYS_DEF];
    logic [CTR_W-1:0]     ctr_mem    [SIG_ENTRIES_DEF];
    logic [SEL_OUT_W-1:0] sel_q;
    logic [THR_W-1:0]     thr_q;
    logic [RATE_W-1:0]    rate_q;
    logic [LEAD_W-1:0]    lead_q;

    rrip_out_t victim_sel_q[$];
    rrip_out_t head_r;
    int        errors;
    bit        calm;
    int        holds_asked;
    int        holds_taken;

    dir_row_t dir_rows [0:19] = '{
        // untouched sets: every way at rrpv 3, lowest way wins; a hit way drops out
        '{OP_VICTIM, 11'd0,    4'd0,  24'h000000, MISS, 1'b1, 4'd0, 10'd511},
        '{OP_VICTIM, 11'd2047, 4'd15, 24'hFFFFFF, MISS, 1'b1, 4'd0, 10'd511},
        '{OP_UPDATE, 11'd7,    4'd0,  24'h000000, HIT,  1'b1, 4'd0, 10'd511},
        '{OP_VICTIM, 11'd7,    4'd0,  24'h000000, MISS, 1'b1, 4'd1, 10'd511},
        '{OP_UPDATE, 11'd7,    4'd15, 24'hFFFFFF, HIT,  1'b1, 4'd0, 10'd511},
        // ship leader fill steps the selector down, bip leader fills step it up
        '{OP_UPDATE, 11'd0,    4'd15, 24'hFFFFFF, MISS, 1'b1, 4'd0, 10'd510},
        '{OP_UPDATE, 11'd32,   4'd0,  24'h000000, MISS, 1'b1, 4'd0, 10'd511},
        '{OP_UPDATE, 11'd63,   4'd1,  24'h00001F, MISS, 1'b1, 4'd0, 10'd512},
        '{OP_VICTIM, 11'd63,   4'd0,  24'h000000, MISS, 1'b1, 4'd0, 10'd512},
        // follower set leaves the selector alone; a further ship leader fill steps it back down
        '{OP_UPDATE, 11'd64,   4'd2,  24'h000020, MISS, 1'b1, 4'd0, 10'd512},
        '{OP_VICTIM, 11'd64,   4'd0,  24'h000000, MISS, 1'b1, 4'd0, 10'd512},
        '{OP_UPDATE, 11'd0,    4'd0,  24'h000000, MISS, 1'b1, 4'd0, 10'd511},
        '{OP_VICTIM, 11'd0,    4'd0,  24'h000000, MISS, 1'b1, 4'd0, 10'd511},
        // victim request ignores the hit flag
        '{OP_VICTIM, 11'd1,    4'd15, 24'hFFFFFF, HIT,  1'b1, 4'd0, 10'd511},
        // reused line trains its signature counter up on eviction
        '{OP_UPDATE, 11'd0,    4'd0,  24'h000000, HIT,  1'b0, 4'd0, 10'd0},
        '{OP_UPDATE, 11'd0,    4'd0,  24'h001001, MISS, 1'b0, 4'd0, 10'd0},
        '{OP_UPDATE, 11'd1000, 4'd8,  24'hABC000, MISS, 1'b0, 4'd0, 10'd0},
        '{OP_VICTIM, 11'd1000, 4'd0,  24'h000000, MISS, 1'b0, 4'd0, 10'd0},
        '{OP_UPDATE, 11'd1500, 4'd3,  24'h800000, MISS, 1'b0, 4'd0, 10'd0},
        '{OP_VICTIM, 11'd7,    4'd0,  24'h000000, MISS, 1'b0, 4'd0, 10'd0}
    };

    ship_bip_dueling_rrip_replacement uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic rrip_clear();
        int s;
        int w;
        begin
            for (s = 0; s < NUM_SETS_DEF; s++) begin
                for (w = 0; w < NUM_WAYS_DEF; w++) begin
                    rrpv_mem[s][w]   = RRPV_MAX;
                    reused_mem[s][w] = 1'b0;
                    sig_mem[s][w]    = '0;
                end
            end
            for (s = 0; s < SIG_ENTRIES_DEF; s++) ctr_mem[s] = CTR_INIT;
            sel_q  = SEL_OUT_W'(SEL_MID);
            thr_q  = THR_RST;
            rate_q = RATE_RST;
            lead_q = LEAD_RST;
        end
    endtask

    // one access against the predicted state; returns victim way and selector
    task automatic rrip_access(input access_t a, output rrip_out_t r);
        int               w;
        int               s;
        logic [RRPV_W-1:0] top;
        logic [WAY_W-1:0] pick;
        logic [SIG_W-1:0] old_sig;
        logic [SIG_W-1:0] new_sig;
        bit               ship_lead;
        bit               bip_lead;
        bit               ship_pick;
        logic [PC_W-1:0]  low_mask;
        begin
            s    = int'(a.set_idx) % NUM_SETS_DEF;
            w    = int'(a.way);
            pick = '0;
            if (a.op == OP_VICTIM) begin
                top = '0;
                for (w = 0; w < NUM_WAYS_DEF; w++)
                    if (rrpv_mem[s][w] > top) top = rrpv_mem[s][w];
                // age the whole set so its oldest lines reach the distant value
                if (top < RRPV_MAX)
                    for (w = 0; w < NUM_WAYS_DEF; w++)
                        rrpv_mem[s][w] = rrpv_mem[s][w] + (RRPV_MAX - top);
                for (w = NUM_WAYS_DEF - 1; w >= 0; w--)
                    if (rrpv_mem[s][w] == RRPV_MAX) pick = WAY_W'(w);
            end else if (w < NUM_WAYS_DEF) begin
                if (a.hit == HIT) begin
                    rrpv_mem[s][w]   = RRPV_NEAR;
                    reused_mem[s][w] = 1'b1;
                end else begin
                    old_sig = sig_mem[s][w];
                    if (reused_mem[s][w]) begin
                        if (ctr_mem[old_sig] < CTR_MAX) ctr_mem[old_sig]++;
                    end else if (ctr_mem[old_sig] > 0) begin
                        ctr_mem[old_sig]--;
                    end
                    ship_lead = s < int'(lead_q);
                    bip_lead  = !ship_lead && s < 2 * int'(lead_q);
                    if (ship_lead) begin
                        if (sel_q != 0) sel_q--;
                    end else if (bip_lead) begin
                        if (int'(sel_q) < SEL_TOP) sel_q++;
                    end
                    new_sig          = SIG_W'(a.pc ^ (a.pc >> SIG_SHIFT));
                    sig_mem[s][w]    = new_sig;
                    reused_mem[s][w] = 1'b0;
                    if (ship_lead) ship_pick = 1'b1;
                    else if (bip_lead) ship_pick = 1'b0;
                    else ship_pick = int'(sel_q) > SEL_MID;
                    if (ship_pick) begin
                        rrpv_mem[s][w] = (ctr_mem[new_sig] >= thr_q) ? RRPV_NEAR : RRPV_MAX;
                    end else begin
                        low_mask       = (PC_W'(1) << rate_q) - PC_W'(1);
                        rrpv_mem[s][w] = ((a.pc & low_mask) == 0) ? RRPV_NEAR : RRPV_MAX;
                    end
                end
            end
            r.victim = pick;
            r.sel    = sel_q;
        end
    endtask

    // offers one access; starts and ends at a falling edge, predicts after acceptance
    task automatic drive_access(input access_t a, input rrip_out_t fixed_r, input bit use_fixed,
                                output logic [WAY_W-1:0] picked);
        int        gap;
        rrip_out_t r;
        begin
            gap = 0;
            if (!calm && $urandom_range(0, 99) < 35) gap = $urandom_range(1, 4);
            repeat (gap) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {1'b0, a.pc, a.way, a.set_idx};
            s_tuser  <= {a.hit, a.op};
            do @(posedge aclk); while (!s_tready);
            @(negedge aclk);
            rrip_access(a, r);
            picked = r.victim;
            victim_sel_q.push_back(use_fixed ? fixed_r : r);
        end
    endtask

    // drop valid and let the block drain before touching registers or finishing
    task automatic settle();
        begin
            s_tvalid <= 1'b0;
            while (victim_sel_q.size() != 0) @(negedge aclk);
            repeat (4) @(negedge aclk);
        end
    endtask

    task automatic program_regs(input logic [THR_W-1:0] thr, input logic [RATE_W-1:0] rate,
                                input logic [LEAD_W-1:0] lead);
        begin
            cfg_wen   <= 1'b1;
            cfg_index <= CFG_REUSE_THRESHOLD;
            cfg_wdata <= CFG_DATA_W'(thr);
            @(negedge aclk);
            cfg_index <= CFG_BIP_RATE_LOG2;
            cfg_wdata <= CFG_DATA_W'(rate);
            @(negedge aclk);
            cfg_index <= CFG_LEADER_SETS;
            cfg_wdata <= CFG_DATA_W'(lead);
            @(negedge aclk);
            cfg_wen <= 1'b0;
            thr_q   = thr;
            rate_q  = rate;
            lead_q  = lead;
        end
    endtask

    // mostly miss sequences (victim request then fill of that way) on a few hot sets
    task automatic run_random(input int count, input bit with_hold);
        int                   made;
        int                   kind;
        int                   i;
        logic [SET_IDX_W-1:0] hot_sets [4];
        logic [PC_W-1:0]      hot_pcs [8];
        access_t              a;
        logic [WAY_W-1:0]     picked;
        begin
            made        = 0;
            hot_sets[0] = (lead_q == 0) ? '0 : lead_q - 1'b1;
            hot_sets[1] = lead_q;
            hot_sets[2] = (2 * int'(lead_q) > NUM_SETS_DEF - 1) ?
                          SET_IDX_W'(NUM_SETS_DEF - 1) : SET_IDX_W'(2 * int'(lead_q));
            hot_sets[3] = SET_IDX_W'($urandom_range(64, NUM_SETS_DEF - 1));
            for (i = 0; i < 8; i++) begin
                hot_pcs[i] = PC_W'($urandom);
                // some pcs with clear low bits so bip inserts near
                if (i < 4) hot_pcs[i][7:0] = '0;
            end
            while (made < count) begin
                kind      = $urandom_range(0, 99);
                a.op      = OP_UPDATE;
                a.set_idx = ($urandom_range(0, 9) == 0) ? SET_IDX_W'($urandom)
                                                        : hot_sets[$urandom_range(0, 3)];
                a.way     = WAY_W'($urandom);
                a.pc      = hot_pcs[$urandom_range(0, 7)];
                a.hit     = HIT;
                if (kind < 45) begin
                    a.op  = OP_VICTIM;
                    a.hit = MISS;
                    drive_access(a, '0, 1'b0, picked);
                    a.op  = OP_UPDATE;
                    a.way = picked;
                    drive_access(a, '0, 1'b0, picked);
                    made += 2;
                end else if (kind < 80) begin
                    drive_access(a, '0, 1'b0, picked);
                    made++;
                end else if (kind < 90) begin
                    a.op  = OP_VICTIM;
                    a.hit = 1'($urandom);
                    drive_access(a, '0, 1'b0, picked);
                    made++;
                end else begin
                    a.op      = 1'($urandom);
                    a.set_idx = SET_IDX_W'($urandom);
                    a.pc      = PC_W'($urandom);
                    a.hit     = 1'($urandom);
                    drive_access(a, '0, 1'b0, picked);
                    made++;
                end
                if (with_hold && made >= 40 && holds_asked == 0) holds_asked++;
            end
        end
    endtask

    // result side: random ready, plus one long hold-off on request
    initial begin
        int k;
        m_tready    = 1'b0;
        holds_taken = 0;
        forever begin
            @(negedge aclk);
            if (holds_taken != holds_asked) begin
                holds_taken++;
                for (k = 0; k < HOLD_CYCLES; k++) begin
                    m_tready <= 1'b0;
                    @(negedge aclk);
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (victim_sel_q.size() == 0) begin
                $display("%0t: result with nothing pending: victim %0d selector %0d",
                         $time, m_tdata[VICT_LSB +: WAY_W], m_tdata[SELV_LSB +: SEL_OUT_W]);
                errors++;
            end else begin
                head_r = victim_sel_q.pop_front();
                if (m_tdata[VICT_LSB +: WAY_W] !== head_r.victim) begin
                    $display("%0t: victim_way expected %0d actual %0d",
                             $time, head_r.victim, m_tdata[VICT_LSB +: WAY_W]);
                    errors++;
                end
                if (m_tdata[SELV_LSB +: SEL_OUT_W] !== head_r.sel) begin
                    $display("%0t: selector_value expected %0d actual %0d",
                             $time, head_r.sel, m_tdata[SELV_LSB +: SEL_OUT_W]);
                    errors++;
                end
            end
        end
    end

    initial begin
        int               r;
        access_t          a;
        rrip_out_t        fixed_r;
        logic [WAY_W-1:0] picked;
        errors      = 0;
        calm        = 1'b0;
        holds_asked = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_wen     = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        rrip_clear();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        for (r = 0; r < 20; r++) begin
            a.op           = dir_rows[r].op;
            a.set_idx      = dir_rows[r].set_idx;
            a.way          = dir_rows[r].way;
            a.pc           = dir_rows[r].pc;
            a.hit          = dir_rows[r].hit;
            fixed_r.victim = dir_rows[r].victim;
            fixed_r.sel    = dir_rows[r].sel;
            drive_access(a, fixed_r, dir_rows[r].fixed, picked);
        end
        run_random(100, 1'b1);
        settle();

        // no leaders at all, threshold and rate at their low ends
        program_regs(2'd0, 3'd0, 11'd0);
        run_random(100, 1'b0);
        settle();

        // half the sets lead each policy, top threshold and rate; no idling here
        calm = 1'b1;
        program_regs(2'd3, 3'd7, 11'd1024);
        run_random(100, 1'b0);
        settle();
        calm = 1'b0;

        // leader count one below the set count, so only the top set leads bip
        program_regs(2'd1, 3'd6, 11'd2047);
        run_random(100, 1'b0);
        settle();
        repeat (4) @(posedge aclk);

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: ship_bip_dueling_rrip_replacement.f
+incdir+sv
sv/sbdr_pkg.sv
sv/sbdr_victim.sv
sv/ship_bip_dueling_rrip_replacement.sv
bench/tb_top.sv
